@@ hw/rtl/rlpg_pkg.sv @@
// shared types and constants of the rgb led pattern generator
package rlpg_pkg;

	// item function codes
	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_STATE   = 2'd1;
	localparam logic [1:0] FUNC_COLOR   = 2'd2;
	localparam logic [1:0] FUNC_PATTERN = 2'd3;

	// machine state codes
	localparam logic [2:0] MS_EXECUTING = 3'd0;
	localparam logic [2:0] MS_STOPPED   = 3'd1;
	localparam logic [2:0] MS_IDLE      = 3'd2;
	localparam logic [2:0] MS_HELD      = 3'd3;
	localparam logic [2:0] MS_ABORTED   = 3'd4;

	// pattern codes
	localparam logic [2:0] PAT_SOLID   = 3'd0;
	localparam logic [2:0] PAT_BLINK   = 3'd1;
	localparam logic [2:0] PAT_FAST    = 3'd2;
	localparam logic [2:0] PAT_BREATHE = 3'd3;
	localparam logic [2:0] PAT_OFF     = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_BLINK_PERIOD  = 3'd0;
	localparam logic [2:0] REG_FAST_PERIOD   = 3'd1;
	localparam logic [2:0] REG_BREATHE_STEP  = 3'd2;
	localparam logic [2:0] REG_BREATHE_INC   = 3'd3;
	localparam logic [2:0] REG_COMMON_ANODE  = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration reset values
	localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;
	localparam logic [15:0] FAST_PERIOD_RST  = 16'd125;
	localparam logic [15:0] BREATHE_STEP_RST = 16'd15;
	localparam logic [7:0]  BREATHE_INC_RST  = 8'd3;

	localparam logic [7:0]  LEVEL_MAX = 8'd255;
	localparam logic [7:0]  AMBER_G   = 8'd200;
	localparam logic [15:0] TICKS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] blink_period;
		logic [15:0] fast_period;
		logic [15:0] breathe_step;
		logic [7:0]  breathe_inc;
		logic        common_anode;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  base_red;
		logic [7:0]  base_green;
		logic [7:0]  base_blue;
		logic [2:0]  pattern;
		logic [15:0] ticks;
		logic        blink_on;
		logic [7:0]  level;
		logic        rising;
	} led_state_t;

endpackage

@@ hw/rtl/rlpg_if.sv @@
// channel interfaces of the rgb led pattern generator
interface rlpg_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [2:0] machine_state;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [2:0] pattern_in;

	modport source(output valid, func, machine_state, red_in, green_in, blue_in, pattern_in,
		input ready);
	modport sink(input valid, func, machine_state, red_in, green_in, blue_in, pattern_in,
		output ready);
endinterface

interface rlpg_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_drive;
	logic [7:0] green_drive;
	logic [7:0] blue_drive;

	modport source(output valid, red_drive, green_drive, blue_drive, input ready);
	modport sink(input valid, red_drive, green_drive, blue_drive, output ready);
endinterface

@@ hw/rtl/rlpg_state.sv @@
// led pattern state registers and their update for one transaction
module rlpg_state (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [1:0]          func,
	input  logic [2:0]          machine_state,
	input  logic [7:0]          red_in,
	input  logic [7:0]          green_in,
	input  logic [7:0]          blue_in,
	input  logic [2:0]          pattern_in,
	input  rlpg_pkg::cfg_t      cfg,
	output rlpg_pkg::led_state_t st
);
	import rlpg_pkg::*;

	led_state_t st_q;
	led_state_t st_nxt;

	always_comb begin
		logic [15:0] cnt;
		logic [15:0] per;
		logic [8:0]  sum;
		logic [2:0]  pat_req;
		logic        pat_ok;

		st_nxt  = st_q;
		cnt     = (st_q.ticks != TICKS_MAX) ? st_q.ticks + 16'd1 : st_q.ticks;
		per     = (st_q.pattern == PAT_BLINK) ? cfg.blink_period : cfg.fast_period;
		sum     = {1'b0, st_q.level} + {1'b0, cfg.breathe_inc};
		pat_req = PAT_OFF;
		pat_ok  = 1'b0;

		case (func)
			FUNC_TICK: begin
				st_nxt.ticks = cnt;
				if (st_q.pattern == PAT_BLINK || st_q.pattern == PAT_FAST) begin
					if (cnt >= per) begin
						st_nxt.ticks    = '0;
						st_nxt.blink_on = ~st_q.blink_on;
					end
				end else if (st_q.pattern == PAT_BREATHE) begin
					if (cnt >= cfg.breathe_step) begin
						st_nxt.ticks = '0;
						if (st_q.rising) begin
							if (sum >= {1'b0, LEVEL_MAX}) begin
								st_nxt.level  = LEVEL_MAX;
								st_nxt.rising = 1'b0;
							end else begin
								st_nxt.level = sum[7:0];
							end
						end else if (st_q.level < cfg.breathe_inc) begin
							st_nxt.level  = '0;
							st_nxt.rising = 1'b1;
						end else begin
							st_nxt.level = st_q.level - cfg.breathe_inc;
						end
					end
				end
			end
			FUNC_STATE: begin
				pat_ok = 1'b1;
				case (machine_state)
					MS_EXECUTING: begin
						st_nxt.base_red = '0; st_nxt.base_green = LEVEL_MAX; st_nxt.base_blue = '0;
						pat_req = PAT_SOLID;
					end
					MS_STOPPED: begin
						st_nxt.base_red = LEVEL_MAX; st_nxt.base_green = '0; st_nxt.base_blue = '0;
						pat_req = PAT_SOLID;
					end
					MS_IDLE: begin
						st_nxt.base_red = LEVEL_MAX; st_nxt.base_green = AMBER_G;
						st_nxt.base_blue = '0;
						pat_req = PAT_BREATHE;
					end
					MS_HELD: begin
						st_nxt.base_red = '0; st_nxt.base_green = '0; st_nxt.base_blue = LEVEL_MAX;
						pat_req = PAT_BLINK;
					end
					MS_ABORTED: begin
						st_nxt.base_red = LEVEL_MAX; st_nxt.base_green = '0; st_nxt.base_blue = '0;
						pat_req = PAT_FAST;
					end
					default: pat_ok = 1'b0;
				endcase
			end
			FUNC_COLOR: begin
				st_nxt.base_red   = red_in;
				st_nxt.base_green = green_in;
				st_nxt.base_blue  = blue_in;
			end
			default: begin
				pat_req = pattern_in;
				pat_ok  = (pattern_in <= PAT_OFF);
			end
		endcase

		// only a real pattern change restarts the timing
		if (pat_ok && pat_req != st_q.pattern) begin
			st_nxt.pattern  = pat_req;
			st_nxt.blink_on = 1'b0;
			st_nxt.level    = '0;
			st_nxt.rising   = 1'b1;
			st_nxt.ticks    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.base_red   <= '0;
			st_q.base_green <= '0;
			st_q.base_blue  <= '0;
			st_q.pattern    <= PAT_OFF;
			st_q.ticks      <= '0;
			st_q.blink_on   <= 1'b0;
			st_q.level      <= '0;
			st_q.rising     <= 1'b1;
		end else if (en) begin
			st_q <= st_nxt;
		end
	end

	assign st = st_q;

endmodule

@@ hw/rtl/rlpg_drive.sv @@
// drive level computation from the pattern state and polarity
module rlpg_drive (
	input  rlpg_pkg::led_state_t st,
	input  logic                 common_anode,
	output logic [7:0]           red_drive,
	output logic [7:0]           green_drive,
	output logic [7:0]           blue_drive
);
	import rlpg_pkg::*;

	// floor(c * level / 255), exact for every product of two 8-bit operands
	function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] lvl);
		logic [15:0] prod;
		logic [16:0] acc;
		prod = c * lvl;
		acc  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
		return acc[15:8];
	endfunction

	function automatic logic [7:0] duty(input logic [7:0] c, input led_state_t s,
		input logic inv);
		logic [7:0] v;
		case (s.pattern)
			PAT_SOLID:   v = c;
			PAT_BLINK,
			PAT_FAST:    v = s.blink_on ? c : 8'd0;
			PAT_BREATHE: v = scale(c, s.level);
			default:     v = 8'd0;
		endcase
		return inv ? ~v : v;
	endfunction

	assign red_drive   = duty(st.base_red, st, common_anode);
	assign green_drive = duty(st.base_green, st, common_anode);
	assign blue_drive  = duty(st.base_blue, st, common_anode);

endmodule

@@ hw/rtl/rgb_led_pattern_generator.sv @@
// top level of the rgb led pattern generator
//
// rgb status led driver. the item channel carries one transaction per
// millisecond tick or command (machine state, color, pattern); the result
// channel returns exactly one transaction per item with the red, green and
// blue pwm duties after pattern and polarity.
// configuration is a plain write port (cfg_we, cfg_idx, cfg_data); the user
// must write it only while no item is in flight, the block does not enforce it.
// an accepted item is registered, then updates the pattern state, then its
// drive levels are registered in the output stage. throughput: one item per
// cycle while the receiver takes results; each of the three stages has its
// own valid bit and advances when the stage behind it is free or moving.
// when the receiver stalls the output holds, the middle stage and input
// register fill, and item.ready falls only once all three hold a transaction.
// reset clears all valid bits, loads the register defaults (periods 500, 125,
// breathe step 15, increment 3, common cathode) and puts the led in the off
// pattern with a black base color.
module rgb_led_pattern_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rlpg_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [rlpg_pkg::CFG_DATA_W-1:0]     cfg_data,
	rlpg_item_if.sink                           item,
	rlpg_result_if.source                       result
);
	import rlpg_pkg::*;

	cfg_t       cfg_q;
	led_state_t st;

	// input register stage
	logic       valid_s1;
	logic [1:0] func_s1;
	logic [2:0] machine_state_s1;
	logic [7:0] red_s1;
	logic [7:0] green_s1;
	logic [7:0] blue_s1;
	logic [2:0] pattern_s1;

	// state applied, drive pending
	logic       valid_s2;

	// output register
	logic       out_valid_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic [7:0] red_d;
	logic [7:0] green_d;
	logic [7:0] blue_d;

	logic out_free;
	logic adv_s2;
	logic adv_s1;
	logic take;

	assign out_free = !out_valid_q || result.ready;
	assign adv_s2   = !valid_s2 || out_free;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign take     = item.valid && adv_s1;

	assign item.ready = adv_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_period <= BLINK_PERIOD_RST;
			cfg_q.fast_period  <= FAST_PERIOD_RST;
			cfg_q.breathe_step <= BREATHE_STEP_RST;
			cfg_q.breathe_inc  <= BREATHE_INC_RST;
			cfg_q.common_anode <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BLINK_PERIOD: cfg_q.blink_period <= cfg_data;
				REG_FAST_PERIOD:  cfg_q.fast_period  <= cfg_data;
				REG_BREATHE_STEP: cfg_q.breathe_step <= cfg_data;
				REG_BREATHE_INC:  cfg_q.breathe_inc  <= cfg_data[7:0];
				REG_COMMON_ANODE: cfg_q.common_anode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= item.valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (out_free)
				out_valid_q <= valid_s2;
		end
	end

	// input payload capture
	always_ff @(posedge clk) begin
		if (take) begin
			func_s1          <= item.func;
			machine_state_s1 <= item.machine_state;
			red_s1           <= item.red_in;
			green_s1         <= item.green_in;
			blue_s1          <= item.blue_in;
			pattern_s1       <= item.pattern_in;
		end
	end

	// pattern state: a stage-one transaction is applied as it moves on
	rlpg_state u_state (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (valid_s1 && adv_s2),
		.func          (func_s1),
		.machine_state (machine_state_s1),
		.red_in        (red_s1),
		.green_in      (green_s1),
		.blue_in       (blue_s1),
		.pattern_in    (pattern_s1),
		.cfg           (cfg_q),
		.st            (st)
	);

	// drive levels from the state left by the stage-two transaction
	rlpg_drive u_drive (
		.st           (st),
		.common_anode (cfg_q.common_anode),
		.red_drive    (red_d),
		.green_drive  (green_d),
		.blue_drive   (blue_d)
	);

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.red_drive   = red_q;
	assign result.green_drive = green_q;
	assign result.blue_drive  = blue_q;

endmodule

@@ bench/led_drive_checker.sv @@
// led drive checker: watches both channels and the register port, predicts each result
`timescale 1ns / 1ps

module led_drive_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rlpg_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [rlpg_pkg::CFG_DATA_W-1:0]     cfg_data,
	rlpg_item_if                                item,
	rlpg_result_if                              result,
	output int                                  fails,
	output int                                  pending,
	output int                                  checked
);
	import rlpg_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} duty_t;

	cfg_t       settings;
	led_state_t led;
	duty_t      duty_q[$];
	duty_t      want;

	initial begin
		fails   = 0;
		pending = 0;
		checked = 0;
	end

	task automatic report(input string msg);
		fails++;
		if (fails <= 40)
			$display("%0t ns mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
		if (got !== exp_v)
			report($sformatf("%s got %0d expected %0d", name, got, exp_v));
	endtask

	function automatic void load_base(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		led.base_red   = r;
		led.base_green = g;
		led.base_blue  = b;
	endfunction

	// only a real change restarts the pattern timing
	function automatic void enter_pattern(input logic [2:0] p);
		if (p > PAT_OFF || p == led.pattern)
			return;
		led.pattern  = p;
		led.blink_on = 1'b0;
		led.level    = 8'd0;
		led.rising   = 1'b1;
		led.ticks    = 16'd0;
	endfunction

	function automatic void advance_ms();
		logic [15:0] period;
		logic [8:0]  sum;
		if (led.ticks != TICKS_MAX)
			led.ticks++;
		if (led.pattern == PAT_BLINK || led.pattern == PAT_FAST) begin
			period = (led.pattern == PAT_BLINK) ? settings.blink_period : settings.fast_period;
			if (led.ticks >= period) begin
				led.ticks    = 16'd0;
				led.blink_on = ~led.blink_on;
			end
		end else if (led.pattern == PAT_BREATHE && led.ticks >= settings.breathe_step) begin
			led.ticks = 16'd0;
			if (led.rising) begin
				sum = {1'b0, led.level} + {1'b0, settings.breathe_inc};
				if (sum >= {1'b0, LEVEL_MAX}) begin
					led.level  = LEVEL_MAX;
					led.rising = 1'b0;
				end else begin
					led.level = sum[7:0];
				end
			end else if (led.level < settings.breathe_inc) begin
				led.level  = 8'd0;
				led.rising = 1'b1;
			end else begin
				led.level = led.level - settings.breathe_inc;
			end
		end
	endfunction

	function automatic logic [7:0] channel_duty(input logic [7:0] c);
		logic [15:0] prod;
		logic [7:0]  v;
		prod = 16'(c) * 16'(led.level);
		case (led.pattern)
			PAT_SOLID:          v = c;
			PAT_BLINK, PAT_FAST: v = led.blink_on ? c : 8'd0;
			PAT_BREATHE:        v = 8'(prod / 16'd255);
			default:            v = 8'd0;
		endcase
		if (settings.common_anode)
			v = LEVEL_MAX - v;
		return v;
	endfunction

	function automatic duty_t predict_duty(input logic [1:0] f, input logic [2:0] ms,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, input logic [2:0] p);
		duty_t d;
		case (f)
			FUNC_TICK: advance_ms();
			FUNC_STATE: begin
				case (ms)
					MS_EXECUTING: begin
						load_base(8'd0, LEVEL_MAX, 8'd0);
						enter_pattern(PAT_SOLID);
					end
					MS_STOPPED: begin
						load_base(LEVEL_MAX, 8'd0, 8'd0);
						enter_pattern(PAT_SOLID);
					end
					MS_IDLE: begin
						load_base(LEVEL_MAX, AMBER_G, 8'd0);
						enter_pattern(PAT_BREATHE);
					end
					MS_HELD: begin
						load_base(8'd0, 8'd0, LEVEL_MAX);
						enter_pattern(PAT_BLINK);
					end
					MS_ABORTED: begin
						load_base(LEVEL_MAX, 8'd0, 8'd0);
						enter_pattern(PAT_FAST);
					end
					default: ;
				endcase
			end
			FUNC_COLOR: load_base(r, g, b);
			default: enter_pattern(p);
		endcase
		d.red   = channel_duty(led.base_red);
		d.green = channel_duty(led.base_green);
		d.blue  = channel_duty(led.base_blue);
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings.blink_period = BLINK_PERIOD_RST;
			settings.fast_period  = FAST_PERIOD_RST;
			settings.breathe_step = BREATHE_STEP_RST;
			settings.breathe_inc  = BREATHE_INC_RST;
			settings.common_anode = 1'b0;
			led         = '0;
			led.pattern = PAT_OFF;
			led.rising  = 1'b1;
			duty_q.delete();
		end else begin
			// results leave in item order, so the oldest expectation belongs to this one
			if (result.valid && result.ready) begin
				checked++;
				if (duty_q.size() == 0) begin
					report($sformatf("result (%0d,%0d,%0d) with nothing expected",
						result.red_drive, result.green_drive, result.blue_drive));
				end else begin
					want = duty_q.pop_front();
					check_field("red_drive", result.red_drive, want.red);
					check_field("green_drive", result.green_drive, want.green);
					check_field("blue_drive", result.blue_drive, want.blue);
				end
			end
			if (item.valid && item.ready)
				duty_q.push_back(predict_duty(item.func, item.machine_state, item.red_in,
					item.green_in, item.blue_in, item.pattern_in));
			if (cfg_we) begin
				case (cfg_idx)
					REG_BLINK_PERIOD: settings.blink_period = cfg_data;
					REG_FAST_PERIOD:  settings.fast_period  = cfg_data;
					REG_BREATHE_STEP: settings.breathe_step = cfg_data;
					REG_BREATHE_INC:  settings.breathe_inc  = cfg_data[7:0];
					REG_COMMON_ANODE: settings.common_anode = cfg_data[0];
					default: ;
				endcase
			end
		end
		pending = duty_q.size();
	end

endmodule

@@ bench/rgb_led_pattern_generator_tb.sv @@
// testbench top: drives commands, ticks and register settings into the led pattern generator
`timescale 1ns / 1ps

module rgb_led_pattern_generator_tb;
	import rlpg_pkg::*;

	// codes above the last legal one, which the block must ignore
	localparam logic [2:0] CODE_BAD_LO = 3'd5;
	localparam logic [2:0] CODE_BAD_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	rlpg_item_if   item_ch();
	rlpg_result_if result_ch();

	int fails;
	int pending;
	int checked;

	int items_sent     = 0;
	int settings_used  = 0;
	int src_idle_pct   = 0;
	int rcv_stall_pct  = 0;
	bit hold_trigger   = 1'b0;

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rgb_led_pattern_generator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	led_drive_checker duty_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.item     (item_ch),
		.result   (result_ch),
		.fails    (fails),
		.pending  (pending),
		.checked  (checked)
	);

	// hard stop in case the block hangs or drops results
	initial begin
		#400_000;
		$display("timeout with %0d results still expected", pending);
		$display("rgb_led_pattern_generator test failed");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off each time hold_trigger flips,
	// counted here so the sender can keep pushing and back the pipeline up
	initial begin
		bit hold_seen;
		int hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	// one transaction on the item channel; valid only drops through the idle loop,
	// so a back-to-back transaction keeps valid high without a glitch
	task automatic send_item(input logic [1:0] f, input logic [2:0] ms, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b, input logic [2:0] p);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.func          <= f;
		item_ch.machine_state <= ms;
		item_ch.red_in        <= r;
		item_ch.green_in      <= g;
		item_ch.blue_in       <= b;
		item_ch.pattern_in    <= p;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	// unused fields carry random garbage, which the block must not look at
	task automatic send_tick();
		send_item(FUNC_TICK, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			3'($urandom));
	endtask

	task automatic send_state(input logic [2:0] ms);
		send_item(FUNC_STATE, ms, 8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom));
	endtask

	task automatic send_color(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		send_item(FUNC_COLOR, 3'($urandom), r, g, b, 3'($urandom));
	endtask

	task automatic send_pattern(input logic [2:0] p);
		send_item(FUNC_PATTERN, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), p);
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// every item returns a result, so an empty expectation queue means idle
	task automatic write_settings(input logic [15:0] blink, input logic [15:0] fast,
		input logic [15:0] step, input logic [7:0] inc, input logic ca);
		logic [CFG_IDX_W-1:0]  idx[5];
		logic [CFG_DATA_W-1:0] vals[5];
		idx  = '{REG_BLINK_PERIOD, REG_FAST_PERIOD, REG_BREATHE_STEP, REG_BREATHE_INC,
			REG_COMMON_ANODE};
		vals = '{blink, fast, step, {8'd0, inc}, {15'd0, ca}};
		drain();
		for (int i = 0; i < 5; i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= idx[i];
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
			1: begin src_idle_pct = 62; rcv_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  rcv_stall_pct = 62; end
			default: begin src_idle_pct = 8; rcv_stall_pct = 8; end
		endcase
	endtask

	// a state or pattern command followed by a run of ticks and occasional color commands,
	// so blink and breathe get time to toggle and ramp; a few commands are out-of-range noise
	task automatic run_sequences(input int n);
		int target;
		int roll;
		target = items_sent + n;
		while (items_sent < target) begin
			roll = $urandom_range(99);
			if (roll < 50)
				send_state(3'($urandom_range(4)));
			else if (roll < 85)
				send_pattern(3'($urandom_range(4)));
			else if (roll < 93)
				send_state(3'($urandom_range(7, 5)));
			else
				send_pattern(3'($urandom_range(7, 5)));
			repeat ($urandom_range(40, 1)) begin
				if ($urandom_range(99) < 8)
					send_color(8'($urandom), 8'($urandom), 8'($urandom));
				else
					send_tick();
			end
		end
	endtask

	// one register setting, swept through all idling modes
	task automatic random_phase(input logic [15:0] blink, input logic [15:0] fast,
		input logic [15:0] step, input logic [7:0] inc, input logic ca);
		write_settings(blink, fast, step, inc, ca);
		for (int mode = 0; mode < 4; mode++) begin
			set_idling(mode);
			// long receiver hold-off while the sender keeps going
			if (mode == 0)
				hold_trigger = ~hold_trigger;
			run_sequences(32);
			// sender pauses until the pipeline is empty
			if (mode == 0)
				drain();
		end
	endtask

	initial begin
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_idx               <= '0;
		cfg_data              <= '0;
		item_ch.valid         <= 1'b0;
		item_ch.func          <= FUNC_TICK;
		item_ch.machine_state <= MS_EXECUTING;
		item_ch.red_in        <= 8'd0;
		item_ch.green_in      <= 8'd0;
		item_ch.blue_in       <= 8'd0;
		item_ch.pattern_in    <= PAT_SOLID;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed part on reset settings
		set_idling(0);
		send_tick();                            // off pattern, black base
		send_color(8'd255, 8'd255, 8'd255);     // color loads but off stays dark
		send_pattern(PAT_SOLID);
		send_pattern(PAT_SOLID);                // same pattern again: no restart
		send_color(8'd0, 8'd0, 8'd0);
		send_color(8'd1, 8'd128, 8'd254);
		send_pattern(CODE_BAD_LO);              // out-of-range pattern ignored
		send_pattern(CODE_BAD_HI);
		send_state(MS_EXECUTING);
		send_tick();
		send_state(MS_STOPPED);
		send_state(MS_IDLE);
		send_tick();
		send_state(MS_HELD);
		send_state(MS_ABORTED);
		send_tick();
		send_state(CODE_BAD_LO);                // out-of-range state ignored
		send_state(CODE_BAD_HI);
		send_pattern(PAT_BREATHE);
		send_pattern(PAT_BLINK);
		send_pattern(PAT_FAST);
		send_pattern(PAT_OFF);
		send_tick();

		// short periods, mid increment, common cathode
		random_phase(16'd3, 16'd1, 16'd2, 8'd40, 1'b0);
		// zero periods and zero increment, common anode
		random_phase(16'd0, 16'd0, 16'd0, 8'd0, 1'b1);
		// largest periods and increment, common cathode
		random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 1'b0);
		// slow ramp, common anode
		random_phase(16'd2, 16'd5, 16'd1, 8'd1, 1'b1);
		// full-scale breathe steps that clamp at both ends
		random_phase(16'd1, 16'd1, 16'd3, 8'd255, 1'b1);

		drain();
		repeat (8) @(negedge clk);
		$display("covered %0d transactions and %0d checked results over %0d register settings",
			items_sent, checked, settings_used);
		$display("zero, mid and full-scale periods, both polarities, all idling mixes, hold-offs");
		if (fails == 0 && pending == 0)
			$display("rgb_led_pattern_generator test passed");
		else
			$display("rgb_led_pattern_generator test failed");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/rlpg_pkg.sv
hw/rtl/rlpg_if.sv
hw/rtl/rlpg_state.sv
hw/rtl/rlpg_drive.sv
hw/rtl/rgb_led_pattern_generator.sv
bench/led_drive_checker.sv
bench/rgb_led_pattern_generator_tb.sv
